// ----- rtl/urah_pkg.sv -----
// ----------------------------------------------------------------------------
// urah_pkg
// Shared types and constants of the rotate-add string hash.
// ----------------------------------------------------------------------------
package urah_pkg;

	localparam int unsigned HASH_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned HASH_ROT  = 19;

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	localparam logic [CFG_IDX_W-1:0] REG_SEED       = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_QUERY  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM_DOT   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_SPACE = 8'd3;

	typedef struct packed {
		logic [HASH_W-1:0] seed;
		logic              end_on_query;
		logic              trim_dotted_tail;
		logic              skip_spaces;
	} cfg_t;

	typedef struct packed {
		logic [HASH_W-1:0] running_hash;
		logic [HASH_W-1:0] hash_before_slash;
		logic              slash_seen;
		logic              dot_after_slash;
		logic              query_stopped;
		logic              nul_seen;
	} hash_state_t;

	function automatic logic [HASH_W-1:0] rotl_hash(input logic [HASH_W-1:0] x);
		return {x[HASH_W-1-HASH_ROT:0], x[HASH_W-1:HASH_W-HASH_ROT]};
	endfunction

	function automatic logic is_white(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

// ----- rtl/urah_cfg.sv -----
// ----------------------------------------------------------------------------
// urah_cfg
// Configuration register file: seed and mode bits.
// ----------------------------------------------------------------------------
module urah_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [urah_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [urah_pkg::HASH_W-1:0]    wr_data,
	output urah_pkg::cfg_t                 cfg
);
	import urah_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SEED:       cfg_q.seed             <= wr_data;
				REG_END_QUERY:  cfg_q.end_on_query     <= wr_data[0];
				REG_TRIM_DOT:   cfg_q.trim_dotted_tail <= wr_data[0];
				REG_SKIP_SPACE: cfg_q.skip_spaces      <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/urah_step.sv -----
// ----------------------------------------------------------------------------
// urah_step
// Per-byte update of the hash state and selection of the string result.
// ----------------------------------------------------------------------------
module urah_step (
	input  urah_pkg::cfg_t               cfg,
	input  urah_pkg::hash_state_t        cur,
	input  logic                         mid_string,
	input  logic [urah_pkg::BYTE_W-1:0]  text_byte,
	output urah_pkg::hash_state_t        nxt,
	output logic [urah_pkg::HASH_W-1:0]  result
);
	import urah_pkg::*;

	hash_state_t       base;
	logic              counted;
	logic [HASH_W-1:0] ext;

	always_comb begin
		if (mid_string) begin
			base = cur;
		end else begin
			base              = '0;
			base.running_hash = cfg.seed;
		end
	end

	assign counted = !base.query_stopped && !base.nul_seen &&
		!(cfg.skip_spaces && is_white(text_byte));
	assign ext = {{(HASH_W-BYTE_W){text_byte[BYTE_W-1]}}, text_byte};

	always_comb begin
		nxt = base;
		if (counted) begin
			if (text_byte == CH_NUL) begin
				nxt.nul_seen = 1'b1;
			end else if (cfg.end_on_query && (text_byte == CH_QUERY)) begin
				nxt.query_stopped = 1'b1;
			end else begin
				if (text_byte == CH_SLASH) begin
					nxt.hash_before_slash = base.running_hash;
					nxt.slash_seen        = 1'b1;
					nxt.dot_after_slash   = 1'b0;
				end else if ((text_byte == CH_DOT) && base.slash_seen) begin
					nxt.dot_after_slash = 1'b1;
				end
				nxt.running_hash = base.running_hash + rotl_hash(base.running_hash) + ext;
			end
		end
	end

	// trim mode is sampled on the final byte
	assign result = (cfg.trim_dotted_tail && !nxt.query_stopped && nxt.slash_seen &&
		nxt.dot_after_slash) ? nxt.hash_before_slash : nxt.running_hash;

endmodule

// ----- rtl/url_path_rotate_add_hash.sv -----
// ----------------------------------------------------------------------------
// url_path_rotate_add_hash
// Rotate-add string hash over a byte stream with query, dot-trim and
// whitespace-skip modes. One item per cycle unless a waiting result is stalled,
// one result per string. The hash is registered and presented in the cycle after the final byte is accepted.
// Throughput: 1 item per cycle; in_ready drops only while a result waits.
// Reset: asynchronous, active low; registers clear to 0, no result pending.
// ----------------------------------------------------------------------------
module url_path_rotate_add_hash (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [urah_pkg::BYTE_W-1:0]    text_byte,
	input  logic                           is_last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [urah_pkg::HASH_W-1:0]    hash_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [urah_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [urah_pkg::HASH_W-1:0]    cfg_data
);
	import urah_pkg::*;

	cfg_t              cfg;
	hash_state_t       state_q;
	hash_state_t       state_nxt;
	logic              mid_q;
	logic              out_valid_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] result;
	logic              in_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	urah_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	urah_step u_step (
		.cfg        (cfg),
		.cur        (state_q),
		.mid_string (mid_q),
		.text_byte  (text_byte),
		.nxt        (state_nxt),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= state_nxt;
				mid_q   <= !is_last;
			end
			if (in_acc && is_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (in_acc && is_last) begin
			hash_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

// ----- rtl/urah_checker.sv -----
// ----------------------------------------------------------------------------
// urah_checker
// Port-level checks of the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module urah_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        is_last,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [urah_pkg::HASH_W-1:0] hash_value
);
	import urah_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_value))
		else $error("result changed while stalled");

	// a final byte always produces a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_last |=> out_valid)
		else $error("final item gave no result");

	// a result appears only after a final byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && is_last))
		else $error("result without final item");

	// input is never blocked while the output side is free
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free output");

endmodule

bind url_path_rotate_add_hash urah_checker u_urah_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.is_last    (is_last),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hash_value (hash_value)
);

// ----- tb/url_path_rotate_add_hash_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_path_rotate_add_hash_test
// Self-checking bench for the rotate-add string hash. Strings go in one byte
// per item while an in-bench model predicts the hash of each string; every
// result is compared in order. Directed strings cover the sign extension,
// seed, query cut, dotted tail, whitespace skip and zero-byte rules. Random
// path-like strings then run under several register settings and
// sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module url_path_rotate_add_hash_test;
	import urah_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    text_byte;
	logic                 is_last;
	logic                 out_valid;
	logic                 out_ready;
	logic [HASH_W-1:0]    hash_value;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [HASH_W-1:0]    cfg_data;

	cfg_t              hash_cfg;
	hash_state_t       str_state;
	logic              in_string;
	logic [HASH_W-1:0] expected_hashes[$];
	int                items_sent;
	int                error_count;
	int                send_gap_pct;
	int                stall_pct;

	url_path_rotate_add_hash u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("url_path_rotate_add_hash verification failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic note_error(input string what, input logic [HASH_W-1:0] want,
			input logic [HASH_W-1:0] got);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hashes.size() == 0) begin
				note_error("unexpected hash", '0, hash_value);
			end else begin
				if (hash_value !== expected_hashes[0])
					note_error("hash mismatch", expected_hashes[0], hash_value);
				void'(expected_hashes.pop_front());
			end
		end
	end

	// Model of one accepted byte; queues the string hash on the final byte.
	function automatic void predict_hash_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [HASH_W-1:0] h;
		logic              white;
		if (!in_string) begin
			str_state = '0;
			str_state.running_hash = hash_cfg.seed;
			in_string = 1'b1;
		end
		white = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
		if (!str_state.query_stopped && !str_state.nul_seen
				&& !(hash_cfg.skip_spaces && white)) begin
			if (b == CH_NUL) begin
				str_state.nul_seen = 1'b1;
			end else if (hash_cfg.end_on_query && b == CH_QUERY) begin
				str_state.query_stopped = 1'b1;
			end else begin
				if (b == CH_SLASH) begin
					str_state.hash_before_slash = str_state.running_hash;
					str_state.slash_seen = 1'b1;
					str_state.dot_after_slash = 1'b0;
				end else if (b == CH_DOT && str_state.slash_seen) begin
					str_state.dot_after_slash = 1'b1;
				end
				h = str_state.running_hash;
				str_state.running_hash = h + {h[12:0], h[31:13]} + {{24{b[7]}}, b};
			end
		end
		if (last) begin
			if (hash_cfg.trim_dotted_tail && !str_state.query_stopped
					&& str_state.slash_seen && str_state.dot_after_slash)
				expected_hashes.push_back(str_state.hash_before_slash);
			else
				expected_hashes.push_back(str_state.running_hash);
			in_string = 1'b0;
		end
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		is_last   <= last;
		do @(posedge clk); while (!in_ready);
		predict_hash_byte(b, last);
		items_sent++;
	endtask

	// Sender pauses until every queued hash has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_hashes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SEED:       hash_cfg.seed = data;
			REG_END_QUERY:  hash_cfg.end_on_query = data[0];
			REG_TRIM_DOT:   hash_cfg.trim_dotted_tail = data[0];
			REG_SKIP_SPACE: hash_cfg.skip_spaces = data[0];
			default: ;
		endcase
	endtask

	// Full register set, plus a write to an unused index that must be ignored.
	task automatic set_modes(input logic [HASH_W-1:0] seed, input logic query,
			input logic trim, input logic skip);
		settle();
		write_reg(REG_SEED, seed);
		write_reg(REG_END_QUERY, {30'd0, 1'($urandom_range(1)), query});
		write_reg(REG_TRIM_DOT, {30'd0, 1'($urandom_range(1)), trim});
		write_reg(REG_SKIP_SPACE, {30'd0, 1'($urandom_range(1)), skip});
		write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] pick_path_byte();
		int r;
		r = $urandom_range(99);
		if (r < 34) return BYTE_W'($urandom_range(8'h61, 8'h7A));
		if (r < 50) return CH_SLASH;
		if (r < 62) return CH_DOT;
		if (r < 69) return CH_QUERY;
		if (r < 78) return BYTE_W'($urandom_range(CH_TAB, CH_CR) | ($urandom_range(1) ? 0 : 8'h20));
		if (r < 80) return CH_NUL;
		if (r < 88) return BYTE_W'($urandom_range(8'h30, 8'h39));
		return BYTE_W'($urandom_range(255));
	endfunction

	task automatic send_random_string();
		int len;
		logic shaped;
		logic [BYTE_W-1:0] b;
		len = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		shaped = ($urandom_range(99) < 80);
		for (int i = 0; i < len; i++) begin
			b = shaped ? pick_path_byte() : BYTE_W'($urandom_range(255));
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic test_plain_strings();
		send_byte(CH_NUL, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_seed_extremes();
		set_modes(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(CH_NUL, 1'b1);
	endtask

	task automatic test_query_cut();
		set_modes($urandom, 1'b1, 1'b1, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_DOT, 1'b0);
		send_byte(CH_QUERY, 1'b0);
		send_byte(8'h78, 1'b1);
		send_byte(CH_QUERY, 1'b1);
	endtask

	task automatic test_dotted_tail();
		set_modes($urandom, 1'b0, 1'b1, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_DOT, 1'b1);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_DOT, 1'b0);
		send_byte(CH_SLASH, 1'b1);
	endtask

	task automatic test_space_skip();
		set_modes($urandom, 1'b0, 1'b1, 1'b1);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_DOT, 1'b0);
		send_byte(8'h0A, 1'b1);
		send_byte(8'h08, 1'b0);
		send_byte(8'h0E, 1'b0);
		send_byte(CH_TAB, 1'b1);
	endtask

	task automatic test_nul_terminator();
		set_modes(32'h0, 1'b0, 1'b1, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_DOT, 1'b1);
	endtask

	task automatic test_random_paths();
		int start;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 67; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 67; end
				default: begin send_gap_pct = 31; stall_pct = 31; end
			endcase
			for (int k = 0; k < 4; k++) begin
				if (k == 0)
					set_modes(32'h0, 1'b0, 1'b0, 1'b0);
				else if (k == 1)
					set_modes(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
				else
					set_modes($urandom, $urandom_range(1), $urandom_range(1),
						$urandom_range(1));
				start = items_sent;
				while (items_sent < start + 33) send_random_string();
				if (phase == 1 || phase == 3)
					settle();
				while (items_sent < start + 66) send_random_string();
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		text_byte    = '0;
		is_last      = 1'b0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		hash_cfg     = '0;
		str_state    = '0;
		in_string    = 1'b0;
		items_sent   = 0;
		error_count  = 0;
		send_gap_pct = 0;
		stall_pct    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_strings();
		test_seed_extremes();
		test_query_cut();
		test_dotted_tail();
		test_space_skip();
		test_nul_terminator();
		test_random_paths();

		settle();
		repeat (10) @(posedge clk);
		if (expected_hashes.size() != 0)
			note_error("hash never returned", expected_hashes[0], '0);
		if (error_count == 0)
			$display("url_path_rotate_add_hash verification clean");
		else
			$display("url_path_rotate_add_hash verification failed");
		$finish;
	end

endmodule
